// ===== hdl/emnc_pkg.sv =====
// ============================================================================
// emnc_pkg
// Shared types and constants for the exact mixed number comparator.
// ============================================================================
package emnc_pkg;

   localparam int NUM_W      = 64;
   localparam int DEN_W      = 63;
   localparam int BITS_W     = 64;
   localparam int KIND_W     = 3;
   localparam int MANT_W     = 53;
   localparam int PROD_W     = 128;
   localparam int EXP_W      = 12;
   localparam int SHIFT_LIM  = 120;
   localparam int FIFO_DEPTH = 4;

   localparam logic [KIND_W-1:0] KIND_RAT         = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DBL         = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POS_INF     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POS_INT_INF = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEG_INT_INF = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NEG_INF     = 3'd5;

   typedef logic signed [1:0] order_type;

   localparam order_type ORD_LT = -2'sd1;
   localparam order_type ORD_EQ = 2'sd0;
   localparam order_type ORD_GT = 2'sd1;

   // done: order already known; rat: cross products; dbl: scaled mantissa
   typedef enum logic [1:0] {
      MODE_DONE = 2'd0,
      MODE_RAT  = 2'd1,
      MODE_DBL  = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      order_type                order;
      logic                     neg;
      logic [NUM_W-1:0]         x1;
      logic [NUM_W-1:0]         y1;
      logic [NUM_W-1:0]         x2;
      logic [NUM_W-1:0]         y2;
      logic signed [EXP_W-1:0]  expo;
   } item_type;

   function automatic order_type neg_order(input order_type c);
      return order_type'(-c);
   endfunction

endpackage

// ===== hdl/exact_mixed_number_compare.sv =====
// ============================================================================
// exact_mixed_number_compare
// Exact three-way order of two numbers, each a rational, a double or an
// infinity.
// ============================================================================
//   channel   ports                      handshake
//   request   req_a_*, req_b_*           taken when start && !busy
//   response  rsp_order                  one-cycle strobe rsp_valid
//
// One item per cycle while busy is low; each result passes through the queue
// and then the four-stage multiply/scale/compare pipeline behind it.
// Synchronous active-high reset empties the queue and the pipeline.
// busy rises only if the queue fills; the pipeline drains every cycle.
module exact_mixed_number_compare import emnc_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [KIND_W-1:0]       req_a_kind,
   input  logic signed [NUM_W-1:0] req_a_num,
   input  logic [DEN_W-1:0]        req_a_den,
   input  logic [BITS_W-1:0]       req_a_bits,
   input  logic [KIND_W-1:0]       req_b_kind,
   input  logic signed [NUM_W-1:0] req_b_num,
   input  logic [DEN_W-1:0]        req_b_den,
   input  logic [BITS_W-1:0]       req_b_bits,
   output logic                    rsp_valid,
   output logic signed [1:0]       rsp_order
);

   item_type  fr_item, q_item;
   logic      q_full, q_empty;
   order_type order;

   emnc_front u_front (
      .a_kind (req_a_kind),
      .a_num  (req_a_num),
      .a_den  (req_a_den),
      .a_bits (req_a_bits),
      .b_kind (req_b_kind),
      .b_num  (req_b_num),
      .b_den  (req_b_den),
      .b_bits (req_b_bits),
      .item   (fr_item)
   );

   emnc_fifo #(.DEPTH(DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (start && !q_full),
      .din   (fr_item),
      .pop   (!q_empty),
      .dout  (q_item),
      .full  (q_full),
      .empty (q_empty)
   );

   emnc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_item   (q_item),
      .out_valid (rsp_valid),
      .out_order (order)
   );

   assign busy      = q_full;
   assign rsp_order = order;

endmodule

// ===== hdl/emnc_front.sv =====
// ============================================================================
// emnc_front
// Classifies an operand pair: settles infinities, double pairs and sign
// cases at once, and sets up the multiply operands for the rest.
// ============================================================================
module emnc_front import emnc_pkg::*; (
   input  logic [KIND_W-1:0]        a_kind,
   input  logic signed [NUM_W-1:0]  a_num,
   input  logic [DEN_W-1:0]         a_den,
   input  logic [BITS_W-1:0]        a_bits,
   input  logic [KIND_W-1:0]        b_kind,
   input  logic signed [NUM_W-1:0]  b_num,
   input  logic [DEN_W-1:0]         b_den,
   input  logic [BITS_W-1:0]        b_bits,
   output item_type                 item
);

   localparam logic [BITS_W-2:0] INF_MAG = 63'h7FF0000000000000;

   function automatic logic signed [2:0] rank(input logic [KIND_W-1:0] k);
      logic signed [2:0] r;
      case (k)
         KIND_POS_INF:     r = 3'sd2;
         KIND_POS_INT_INF: r = 3'sd1;
         KIND_NEG_INT_INF: r = -3'sd1;
         KIND_NEG_INF:     r = -3'sd2;
         default:          r = 3'sd0;
      endcase
      return r;
   endfunction

   function automatic order_type sgn3(input logic signed [2:0] x,
                                      input logic signed [2:0] y);
      return (x > y) ? ORD_GT : ((x < y) ? ORD_LT : ORD_EQ);
   endfunction

   function automatic logic signed [2:0] num_sign(input logic signed [NUM_W-1:0] p);
      return (p == '0) ? 3'sd0 : (p[NUM_W-1] ? -3'sd1 : 3'sd1);
   endfunction

   function automatic logic [NUM_W-1:0] num_mag(input logic signed [NUM_W-1:0] p);
      return p[NUM_W-1] ? (~p + 64'd1) : p;
   endfunction

   // order-preserving key; both zeros map to the same key
   function automatic logic [BITS_W-1:0] dbl_key(input logic [BITS_W-1:0] b);
      logic [BITS_W-1:0] k;
      if (b[BITS_W-2:0] == '0) begin
         k = {1'b1, {(BITS_W-1){1'b0}}};
      end else if (b[BITS_W-1]) begin
         k = ~b;
      end else begin
         k = {1'b1, b[BITS_W-2:0]};
      end
      return k;
   endfunction

   logic signed [2:0]        ra, rb, sv, sp, s1, s2;
   logic                     a_dbl, b_dbl, swap, nan_a, nan_b;
   logic [BITS_W-1:0]        dbits, key_a, key_b;
   logic signed [NUM_W-1:0]  rp;
   logic [DEN_W-1:0]         rq;
   logic [10:0]              ex, ex_eff;
   logic [MANT_W-1:0]        mant;
   order_type                c;

   assign ra    = rank(a_kind);
   assign rb    = rank(b_kind);
   assign a_dbl = (a_kind == KIND_DBL);
   assign b_dbl = (b_kind == KIND_DBL);
   assign swap  = !a_dbl;
   assign dbits = a_dbl ? a_bits : b_bits;
   assign rp    = a_dbl ? b_num : a_num;
   assign rq    = a_dbl ? b_den : a_den;
   assign sv    = (dbits[BITS_W-2:0] == '0 || dbits[BITS_W-2:0] > INF_MAG) ? 3'sd0 :
                  (dbits[BITS_W-1] ? -3'sd1 : 3'sd1);
   assign sp    = num_sign(rp);
   assign c     = sgn3(sv, sp);
   assign ex    = dbits[62:52];
   assign ex_eff = (ex != '0) ? ex : 11'd1;
   assign mant  = {ex != '0, dbits[51:0]};
   assign nan_a = a_bits[BITS_W-2:0] > INF_MAG;
   assign nan_b = b_bits[BITS_W-2:0] > INF_MAG;
   assign key_a = dbl_key(a_bits);
   assign key_b = dbl_key(b_bits);
   assign s1    = (b_den != '0) ? num_sign(a_num) : 3'sd0;
   assign s2    = (a_den != '0) ? num_sign(b_num) : 3'sd0;

   always_comb begin
      item       = '0;
      item.mode  = MODE_DONE;
      item.order = ORD_EQ;
      if (ra != 3'sd0 || rb != 3'sd0) begin
         item.order = sgn3(ra, rb);
      end else if (a_dbl && b_dbl) begin
         if (!nan_a && !nan_b) begin
            item.order = (key_a > key_b) ? ORD_GT : ((key_a < key_b) ? ORD_LT : ORD_EQ);
         end
      end else if (a_dbl || b_dbl) begin
         if (c != ORD_EQ || rp == '0) begin
            item.order = swap ? neg_order(c) : c;
         end else if (ex == 11'h7FF) begin
            item.order = swap ? neg_order(order_type'(sv)) : order_type'(sv);
         end else begin
            item.mode = MODE_DBL;
            item.neg  = (sp < 0) ^ swap;
            item.x1   = {{(NUM_W-MANT_W){1'b0}}, mant};
            item.y1   = {1'b0, rq};
            item.x2   = num_mag(rp);
            item.y2   = 64'd1;
            item.expo = $signed({1'b0, ex_eff}) - 12'sd1075;
         end
      end else begin
         if (s1 != s2 || s1 == 3'sd0) begin
            item.order = sgn3(s1, s2);
         end else begin
            item.mode = MODE_RAT;
            item.neg  = (s1 < 0);
            item.x1   = num_mag(a_num);
            item.y1   = {1'b0, b_den};
            item.x2   = num_mag(b_num);
            item.y2   = {1'b0, a_den};
         end
      end
   end

endmodule

// ===== hdl/emnc_fifo.sv =====
// ============================================================================
// emnc_fifo
// Short item queue between the classifier and the compare pipeline.
// ============================================================================
module emnc_fifo import emnc_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type din,
   input  logic     pop,
   output item_type dout,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// ===== hdl/emnc_back.sv =====
// ============================================================================
// emnc_back
// Four-stage compare pipeline: 32x32 partial products, 128-bit sums,
// exponent scaling with range check, final compare and sign fix.
// ============================================================================
module emnc_back import emnc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  item_type  in_item,
   output logic      out_valid,
   output order_type out_order
);

   typedef struct packed {
      mode_type                mode;
      order_type               order;
      logic                    neg;
      logic signed [EXP_W-1:0] expo;
   } ctl_type;

   // stage 1: partial products
   logic           v1_ff;
   ctl_type        c1_ff;
   logic [63:0]    pp_ff [8];
   // stage 2: full products
   logic           v2_ff;
   ctl_type        c2_ff;
   logic [PROD_W-1:0] p1_ff, p2_ff;
   // stage 3: scaled operands
   logic           v3_ff;
   ctl_type        c3_ff;
   logic           frc_ff, frc_in;
   order_type      fval_ff, fval_in;
   logic [PROD_W-1:0] l_ff, l_in, r_ff, r_in;
   // stage 4: result
   logic           v4_ff;
   order_type      ord_ff, ord_in;

   logic [EXP_W-1:0] nexp;
   logic [6:0]       sh;
   order_type        cmp;

   function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
      return {32'b0, x} * {32'b0, y};
   endfunction

   function automatic logic [PROD_W-1:0] sum4(input logic [63:0] p00, input logic [63:0] p01,
                                               input logic [63:0] p10, input logic [63:0] p11);
      return {64'b0, p00} + {32'b0, p01, 32'b0} + {32'b0, p10, 32'b0} + {p11, 64'b0};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff    <= '{in_item.mode, in_item.order, in_item.neg, in_item.expo};
      pp_ff[0] <= mul32(in_item.x1[31:0],  in_item.y1[31:0]);
      pp_ff[1] <= mul32(in_item.x1[31:0],  in_item.y1[63:32]);
      pp_ff[2] <= mul32(in_item.x1[63:32], in_item.y1[31:0]);
      pp_ff[3] <= mul32(in_item.x1[63:32], in_item.y1[63:32]);
      pp_ff[4] <= mul32(in_item.x2[31:0],  in_item.y2[31:0]);
      pp_ff[5] <= mul32(in_item.x2[31:0],  in_item.y2[63:32]);
      pp_ff[6] <= mul32(in_item.x2[63:32], in_item.y2[31:0]);
      pp_ff[7] <= mul32(in_item.x2[63:32], in_item.y2[63:32]);
      c2_ff    <= c1_ff;
      p1_ff    <= sum4(pp_ff[0], pp_ff[1], pp_ff[2], pp_ff[3]);
      p2_ff    <= sum4(pp_ff[4], pp_ff[5], pp_ff[6], pp_ff[7]);
      c3_ff    <= c2_ff;
      frc_ff   <= frc_in;
      fval_ff  <= fval_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      ord_ff   <= ord_in;
   end

   // mantissa*q scaled by 2^e against |p|; out-of-range shifts decide early
   assign nexp = EXP_W'(-c2_ff.expo);

   always_comb begin
      frc_in  = 1'b0;
      fval_in = ORD_EQ;
      l_in    = p1_ff;
      r_in    = p2_ff;
      sh      = '0;
      if (c2_ff.mode == MODE_DBL) begin
         if (!c2_ff.expo[EXP_W-1]) begin
            if (c2_ff.expo > 12'sd64) begin
               frc_in  = 1'b1;
               fval_in = ORD_GT;
            end else begin
               sh = c2_ff.expo[6:0];
               if ((p1_ff >> (7'd64 - sh)) != '0) begin
                  frc_in  = 1'b1;
                  fval_in = ORD_GT;
               end
               l_in = p1_ff << sh;
            end
         end else begin
            if (nexp > EXP_W'(SHIFT_LIM)) begin
               frc_in  = 1'b1;
               fval_in = ORD_LT;
            end else begin
               sh = nexp[6:0];
               if ((p2_ff >> (7'(SHIFT_LIM) - sh)) != '0) begin
                  frc_in  = 1'b1;
                  fval_in = ORD_LT;
               end
               r_in = p2_ff << sh;
            end
         end
      end
   end

   assign cmp = frc_ff ? fval_ff :
                ((l_ff > r_ff) ? ORD_GT : ((l_ff < r_ff) ? ORD_LT : ORD_EQ));

   always_comb begin
      if (c3_ff.mode == MODE_DONE) begin
         ord_in = c3_ff.order;
      end else begin
         ord_in = c3_ff.neg ? neg_order(cmp) : cmp;
      end
   end

   assign out_valid = v4_ff;
   assign out_order = ord_ff;

endmodule

// ===== hdl/emnc_check.sv =====
// ============================================================================
// emnc_check
// Port-level checks for the comparator, bound to the top level.
// ============================================================================
module emnc_check import emnc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [KIND_W-1:0]   req_a_kind,
   input logic [KIND_W-1:0]   req_b_kind,
   input logic                rsp_valid,
   input logic signed [1:0]   rsp_order
);

   a_no_backlog: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled although pipeline drains every cycle");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("item produced no result after five cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without a matching item");

   a_top_inf: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_a_kind == KIND_POS_INF && req_b_kind != KIND_POS_INF)
      |-> ##5 (rsp_order == ORD_GT))
      else $error("+oo did not rank above the other operand");

endmodule

bind exact_mixed_number_compare emnc_check u_check (.*);
